/* src/irpc_pkg.sv */
// irpc_pkg: shared types and fixed constants for the ir pulse capture and replay unit
// used by irpc_store, irpc_core and ir_pulse_capture_replay_unit; depends on nothing
package irpc_pkg;

  localparam int COUNT_W = 16;
  localparam int GAP_W   = 20;
  localparam int LEN_W   = 9;
  localparam int IN_W    = 8;
  localparam int OUT_W   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [GAP_W-1:0]   GAP_RESET = 20'd100000;

  // bit positions of the result fields in the output tdata
  localparam int OUT_CARRIER = 0;
  localparam int OUT_PRESENT = 1;
  localparam int OUT_LEN_LO  = 2;
  localparam int OUT_BUSY    = 11;
  localparam int OUT_FULL    = 12;

  typedef struct packed {
    logic armed;
    logic present;
    logic busy;
    logic full;
  } irpc_status_t;

endpackage

/* src/irpc_store.sv */
// irpc_store: duration memory, one write port and one registered read port
// entries at or past the fill count, and entry 0, read as zero; uses irpc_pkg
module irpc_store #(
  parameter int STORE_DEPTH = 512,
  parameter int AW          = 9,
  parameter int WIW         = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [irpc_pkg::COUNT_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr,
  input  logic [WIW-1:0]               fill,
  output logic [irpc_pkg::COUNT_W-1:0] rd_entry
);
  import irpc_pkg::*;

  logic [COUNT_W-1:0] mem [STORE_DEPTH];
  logic [COUNT_W-1:0] rd_data;
  logic               rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // entry 0 is never written; entries from the fill count upward were never written
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= (rd_addr != '0) && ((AW+WIW)'(rd_addr) < (AW+WIW)'(fill));
    end
  end

  assign rd_entry = rd_ok ? rd_data : '0;

endmodule

/* src/irpc_core.sv */
// irpc_core: capture timer, write pointer, replay sequencer, gap timer and detection
// produces the next result word and drives the duration store; uses irpc_pkg
module irpc_core #(
  parameter int STORE_DEPTH   = 512,
  parameter int CHECK_ENTRIES = 5,
  parameter int AW            = 9,
  parameter int WIW           = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         tick,
  input  logic                         edge_req,
  input  logic                         button,
  input  logic [irpc_pkg::GAP_W-1:0]   gap_ticks,
  input  logic [irpc_pkg::COUNT_W-1:0] entry,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [irpc_pkg::COUNT_W-1:0] wr_data,
  output logic [AW-1:0]                rd_addr,
  output logic [WIW-1:0]               fill,
  output irpc_pkg::irpc_status_t       status,
  output logic [irpc_pkg::OUT_W-1:0]   res_next
);
  import irpc_pkg::*;

  // checked entries past the end of the store always read as zero
  localparam int CHK_LIM = (CHECK_ENTRIES < STORE_DEPTH) ? CHECK_ENTRIES : STORE_DEPTH;

  logic               armed, armed_next;
  logic               timer_running, timer_running_next;
  logic [COUNT_W-1:0] interval_count, interval_count_next;
  logic [WIW-1:0]     write_index, write_index_next;
  logic [AW-1:0]      last_nonzero, last_nonzero_next;
  logic               present, present_next;
  logic [AW-1:0]      length_reg, length_reg_next;
  logic               busy, busy_next;
  logic [AW-1:0]      play_index, play_index_next;
  logic [COUNT_W-1:0] play_count, play_count_next;
  logic [GAP_W-1:0]   gap_count, gap_count_next;
  logic               full, full_next;
  logic               room;
  logic [AW+LEN_W-1:0] len_ext;

  assign room    = write_index < WIW'(STORE_DEPTH);
  assign wr_en   = en && armed && edge_req && room;
  assign wr_addr = write_index[AW-1:0];
  assign wr_data = interval_count;

  always_comb begin
    armed_next          = armed;
    timer_running_next  = timer_running;
    interval_count_next = interval_count;
    write_index_next    = write_index;
    last_nonzero_next   = last_nonzero;
    length_reg_next     = length_reg;
    busy_next           = busy;
    play_index_next     = play_index;
    play_count_next     = play_count;
    gap_count_next      = gap_count;
    full_next           = full;

    // capture
    if (armed && edge_req) begin
      if (room) begin
        if (interval_count != '0) begin
          last_nonzero_next = write_index[AW-1:0];
        end
        write_index_next    = write_index + WIW'(1);
        interval_count_next = '0;
        timer_running_next  = 1'b1;
      end else begin
        full_next = 1'b1;
      end
    end else if (timer_running && tick && (interval_count != COUNT_MAX)) begin
      interval_count_next = interval_count + COUNT_W'(1);
    end

    // replay, gap, start
    if (busy) begin
      if (tick) begin
        if (play_count >= entry) begin
          if (play_index >= length_reg) begin
            busy_next      = 1'b0;
            gap_count_next = gap_ticks;
          end else begin
            play_index_next = play_index + AW'(1);
          end
          play_count_next = '0;
        end else begin
          play_count_next = play_count + COUNT_W'(1);
        end
      end
    end else if (gap_count != '0) begin
      if (tick) begin
        gap_count_next = gap_count - GAP_W'(1);
      end
    end else if (button && present) begin
      // first replay latches the length and ends capture
      if (armed) begin
        length_reg_next    = last_nonzero_next;
        armed_next         = 1'b0;
        timer_running_next = 1'b0;
      end
      busy_next       = 1'b1;
      play_index_next = '0;
      play_count_next = '0;
    end

    // detection only needs to watch writes into the checked entries
    present_next = present ||
                   (armed && edge_req && room && (interval_count != '0) &&
                    (write_index < WIW'(CHK_LIM)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b1;
      timer_running  <= 1'b0;
      interval_count <= '0;
      write_index    <= WIW'(1);
      last_nonzero   <= '0;
      present        <= 1'b0;
      length_reg     <= '0;
      busy           <= 1'b0;
      play_index     <= '0;
      play_count     <= '0;
      gap_count      <= '0;
      full           <= 1'b0;
    end else if (en) begin
      armed          <= armed_next;
      timer_running  <= timer_running_next;
      interval_count <= interval_count_next;
      write_index    <= write_index_next;
      last_nonzero   <= last_nonzero_next;
      present        <= present_next;
      length_reg     <= length_reg_next;
      busy           <= busy_next;
      play_index     <= play_index_next;
      play_count     <= play_count_next;
      gap_count      <= gap_count_next;
      full           <= full_next;
    end
  end

  // prefetch the entry the sequencer will look at on the next transfer
  assign rd_addr = en ? play_index_next : play_index;
  assign fill    = en ? write_index_next : write_index;

  assign status.armed   = armed;
  assign status.present = present;
  assign status.busy    = busy;
  assign status.full    = full;

  assign len_ext = {{LEN_W{1'b0}}, length_reg_next};

  always_comb begin
    res_next = '0;
    res_next[OUT_CARRIER]                  = busy_next && !play_index_next[0];
    res_next[OUT_PRESENT]                  = present_next;
    res_next[OUT_LEN_LO +: LEN_W]          = len_ext[LEN_W-1:0];
    res_next[OUT_BUSY]                     = busy_next;
    res_next[OUT_FULL]                     = full_next;
  end

endmodule

/* src/ir_pulse_capture_replay_unit.sv */
// ir_pulse_capture_replay_unit: learns an infrared pulse train and plays it back
// the result of a transfer is registered into the output register when the transfer is taken
// throughput: one item per cycle while m_tready keeps up; the output register frees itself when the result is taken
// the replay entry is prefetched from the duration memory's registered read port
// reset: synchronous; control state cleared, gap register to 100000 ticks, the duration
// memory is not swept: a fill count makes never-written entries read as zero
module ir_pulse_capture_replay_unit #(
  parameter int STORE_DEPTH   = 512,
  parameter int CHECK_ENTRIES = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [irpc_pkg::GAP_W-1:0]  cfg_wdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [irpc_pkg::IN_W-1:0]   s_tdata,   // tick, edge_req, button, zero fill
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [irpc_pkg::OUT_W-1:0]  m_tdata    // carrier_on, signal_present,
                                                 // signal_length[8:0], replay_busy,
                                                 // capture_full, zero fill
);
  import irpc_pkg::*;

  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int WIW = $clog2(STORE_DEPTH + 1);

  logic [GAP_W-1:0]   gap_ticks;
  logic               accept;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr;
  logic [WIW-1:0]     fill;
  logic [COUNT_W-1:0] entry;
  irpc_status_t       status;
  logic [OUT_W-1:0]   res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_ticks <= GAP_RESET;
    end else if (cfg_we) begin
      gap_ticks <= cfg_wdata;
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  irpc_core #(
    .STORE_DEPTH  (STORE_DEPTH),
    .CHECK_ENTRIES(CHECK_ENTRIES),
    .AW           (AW),
    .WIW          (WIW)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .en       (accept),
    .tick     (s_tdata[0]),
    .edge_req (s_tdata[1]),
    .button   (s_tdata[2]),
    .gap_ticks(gap_ticks),
    .entry    (entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .fill     (fill),
    .status   (status),
    .res_next (res_next)
  );

  irpc_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW),
    .WIW        (WIW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .fill    (fill),
    .rd_entry(entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= res_next;
    end
  end

  // replay only runs once capture has ended
  a_busy_disarmed: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !status.armed)
    else $error("replay running while capture still armed");

  // no store writes during replay
  a_no_write_in_replay: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !wr_en)
    else $error("duration store written during replay");

  // a recognised signal never goes away
  a_present_sticky: assert property (@(posedge clk) disable iff (rst)
    status.present |=> status.present)
    else $error("signal present flag dropped");

  // carrier only while replaying
  a_carrier_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[OUT_CARRIER] || m_tdata[OUT_BUSY]))
    else $error("carrier on without replay");

endmodule

/* tb/sv/tb_ir_pulse_capture_replay_unit.sv */
`timescale 1ns / 1ps
// tb_ir_pulse_capture_replay_unit: self-checking bench for the ir pulse capture and replay unit
// one learn session then several replays, checked against a transfer-level model of the unit
// depends on irpc_pkg and ir_pulse_capture_replay_unit
module tb_ir_pulse_capture_replay_unit;
  import irpc_pkg::*;

  localparam int STORE_ENTRIES   = 512;
  localparam int CHECKED_ENTRIES = 5;
  localparam int IDX_W           = $clog2(STORE_ENTRIES);

  // bit positions of the flags in the input tdata
  localparam int IN_TICK   = 0;
  localparam int IN_EDGE   = 1;
  localparam int IN_BUTTON = 2;

  localparam int          CHUNK       = 32;
  localparam int unsigned SAFE_MARGIN = 40;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned PRINT_CAP   = 100;
  localparam logic [GAP_W-1:0] GAP_MAX = '1;

  typedef struct packed {
    bit             carrier;
    bit             present;
    bit [LEN_W-1:0] length;
    bit             busy;
    bit             full;
  } ir_status_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [GAP_W-1:0] cfg_wdata = '0;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata   = '0;  // tick, edge_req, button, zero fill
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [OUT_W-1:0] m_tdata;         // carrier_on, signal_present, signal_length[8:0],
                                     // replay_busy, capture_full, zero fill

  ir_pulse_capture_replay_unit #(
    .STORE_DEPTH  (STORE_ENTRIES),
    .CHECK_ENTRIES(CHECKED_ENTRIES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // model of the unit
  bit [GAP_W-1:0]   gap_setting = GAP_RESET;
  bit               ir_armed    = 1'b1;
  bit               ir_timing;
  bit [COUNT_W-1:0] ir_interval;
  int unsigned      ir_wr_idx   = 1;
  bit [COUNT_W-1:0] learned_dur [STORE_ENTRIES];
  int unsigned      ir_last_nz;
  int unsigned      ir_len;
  int unsigned      ir_play_idx;
  int unsigned      ir_play_cnt;
  int unsigned      ir_gap_left;
  bit               ir_present;
  bit               ir_busy;
  bit               ir_full;
  int unsigned      replays_started;

  logic [IN_W-1:0] pending_items [$];
  ir_status_t      expected_status_q [$];

  int unsigned mismatch_count;
  int unsigned status_count;
  int unsigned cycle_count;
  int          send_idle_pct = 17;
  int          recv_idle_pct = 69;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic step_ir_model(input logic [IN_W-1:0] flags);
    bit         tick;
    bit         edg;
    bit         btn;
    bit         was_present;
    bit         was_busy;
    int         i;
    ir_status_t st;
    tick        = flags[IN_TICK];
    edg         = flags[IN_EDGE];
    btn         = flags[IN_BUTTON];
    was_present = ir_present;
    was_busy    = ir_busy;
    if (ir_armed && edg) begin
      if (ir_wr_idx < STORE_ENTRIES) begin
        learned_dur[ir_wr_idx[IDX_W-1:0]] = ir_interval;
        if (ir_interval != '0) ir_last_nz = ir_wr_idx;
        ir_wr_idx++;
        ir_interval = '0;
        ir_timing   = 1'b1;
      end else begin
        ir_full = 1'b1;
      end
    end else if (ir_timing && tick && ir_interval != COUNT_MAX) begin
      ir_interval++;
    end
    // replay and gap work on the state from before this transfer
    if (was_busy) begin
      if (tick) begin
        if (ir_play_cnt >= 32'(learned_dur[ir_play_idx[IDX_W-1:0]])) begin
          if (ir_play_idx >= ir_len) begin
            ir_busy     = 1'b0;
            ir_gap_left = 32'(gap_setting);
          end else begin
            ir_play_idx++;
          end
          ir_play_cnt = 0;
        end else begin
          ir_play_cnt++;
        end
      end
    end else if (ir_gap_left > 0) begin
      if (tick) ir_gap_left--;
    end else if (btn && was_present) begin
      if (ir_armed) begin
        ir_len    = ir_last_nz;
        ir_armed  = 1'b0;
        ir_timing = 1'b0;
      end
      ir_busy     = 1'b1;
      ir_play_idx = 0;
      ir_play_cnt = 0;
      replays_started++;
    end
    if (!ir_present) begin
      for (i = 0; i < CHECKED_ENTRIES; i++)
        if (learned_dur[i[IDX_W-1:0]] != '0) ir_present = 1'b1;
    end
    st.carrier = ir_busy && !ir_play_idx[0];
    st.present = ir_present;
    st.length  = ir_len[LEN_W-1:0];
    st.busy    = ir_busy;
    st.full    = ir_full;
    expected_status_q.push_back(st);
  endtask

  // ticks still to come before the current replay ends
  function automatic int unsigned replay_ticks_left();
    int unsigned left;
    int unsigned k;
    if (!ir_busy) return 0;
    left = 32'(learned_dur[ir_play_idx[IDX_W-1:0]]) - ir_play_cnt + 1;
    for (k = ir_play_idx + 1; k <= ir_len; k++)
      left += 32'(learned_dur[k[IDX_W-1:0]]) + 1;
    return left;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] %s: got %0d, expected %0d at status %0d",
               $realtime, what, got, want, status_count);
    mismatch_count++;
  endtask

  task automatic check_status(input logic [OUT_W-1:0] word);
    ir_status_t want;
    status_count++;
    if (expected_status_q.size() == 0) begin
      report_mismatch("status transfer with nothing expected", 32'(word), 0);
      return;
    end
    want = expected_status_q.pop_front();
    if (word[OUT_CARRIER] !== want.carrier)
      report_mismatch("carrier_on", 32'(word[OUT_CARRIER]), 32'(want.carrier));
    if (word[OUT_PRESENT] !== want.present)
      report_mismatch("signal_present", 32'(word[OUT_PRESENT]), 32'(want.present));
    if (word[OUT_LEN_LO +: LEN_W] !== want.length)
      report_mismatch("signal_length", 32'(word[OUT_LEN_LO +: LEN_W]), 32'(want.length));
    if (word[OUT_BUSY] !== want.busy)
      report_mismatch("replay_busy", 32'(word[OUT_BUSY]), 32'(want.busy));
    if (word[OUT_FULL] !== want.full)
      report_mismatch("capture_full", 32'(word[OUT_FULL]), 32'(want.full));
  endtask

  // driver: presents pending items, predicts each one on its transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) step_ir_model(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata  <= pending_items.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_status(m_tdata);
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input bit t, input bit e, input bit b);
    logic [IN_W-1:0] w;
    w            = '0;
    w[IN_TICK]   = t;
    w[IN_EDGE]   = e;
    w[IN_BUTTON] = b;
    pending_items.push_back(w);
  endtask

  // hold off until every queued item is through and every status has come back
  task automatic settle();
    while (pending_items.size() != 0 || s_tvalid || expected_status_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_gap(input logic [GAP_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    gap_setting  = value;
  endtask

  // press the button, then feed ticks until the replay is over; buttons pressed
  // mid-replay must be ignored, but are kept clear of the end unless a
  // back-to-back restart is wanted
  task automatic run_replay(input bit retrigger);
    int unsigned first_start;
    int unsigned left;
    bit          btn;
    push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
    settle();
    first_start = replays_started;
    while (ir_busy) begin
      left = replay_ticks_left();
      repeat (CHUNK) begin
        if (left > SAFE_MARGIN) btn = 1'($urandom_range(0, 1));
        else btn = retrigger && replays_started == first_start;
        push_item($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), btn);
      end
      settle();
    end
  endtask

  task automatic run_gap();
    bit btn_ok;
    while (ir_gap_left > 0) begin
      btn_ok = ir_gap_left > SAFE_MARGIN;
      repeat (CHUNK)
        push_item($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
                  btn_ok && $urandom_range(0, 1) != 0);
      settle();
    end
  endtask

  initial begin
    int unsigned idx;
    int unsigned nt;
    int unsigned nz_until;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_gap(20'd1);

    // no signal yet: button ignored, ticks ignored until the first edge
    push_item(1'b0, 1'b0, 1'b0);
    push_item(1'b0, 1'b0, 1'b1);
    push_item(1'b1, 1'b0, 1'b0);
    // first edge stores zero, its tick not counted
    push_item(1'b1, 1'b1, 1'b0);
    push_item(1'b1, 1'b0, 1'b0);
    push_item(1'b1, 1'b0, 1'b0);
    push_item(1'b0, 1'b0, 1'b0);
    // edge with button: the signal only becomes present on this transfer
    push_item(1'b0, 1'b1, 1'b1);
    repeat (3) push_item(1'b1, 1'b0, 1'b0);
    push_item(1'b1, 1'b1, 1'b0);
    push_item(1'b0, 1'b1, 1'b0);
    settle();

    // rest of the capture: short random intervals, then an all-zero tail
    // run past the end of the store
    nz_until = ir_wr_idx + $urandom_range(8, 20);
    for (idx = ir_wr_idx; idx < STORE_ENTRIES + 3; idx++) begin
      if (idx < nz_until) nt = $urandom_range(0, 4);
      else nt = 0;
      repeat (nt) begin
        if ($urandom_range(0, 3) == 0) push_item(1'b0, 1'b0, 1'b0);
        push_item(1'b1, 1'b0, 1'b0);
      end
      if ($urandom_range(0, 7) == 0) push_item(1'b0, 1'b0, 1'b0);
      push_item(1'($urandom_range(0, 1)), 1'b1, 1'b0);
    end
    settle();

    send_idle_pct = 69;
    recv_idle_pct = 17;
    write_gap(20'd300);
    run_replay(1'b0);
    run_gap();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // zero gap: a held button restarts the replay straight after it ends
    write_gap('0);
    run_replay(1'b1);

    write_gap(GAP_MAX);
    run_replay(1'b0);
    // long gap now running: buttons and edges must change nothing
    repeat (100)
      push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    settle();
    repeat (10) @(posedge clk);

    if (expected_status_q.size() != 0)
      report_mismatch("statuses never delivered", 0, 32'(expected_status_q.size()));
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
